[hw/rtl/rsid_pkg.sv]
// Shared types and constants for the row SAD interlace detector.
package rsid_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned ROW_BYTES_W   = 11;
  localparam int unsigned SUM_W         = 18;
  localparam int unsigned ROW_IDX_W     = 2;
  localparam int unsigned OUT_TDATA_W   = 56;

  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = ROW_BYTES_W'(640);
  localparam logic [SUM_W-1:0]       SUM_MAX       = {SUM_W{1'b1}};

  // Row codes within the three analyzed rows
  localparam logic [ROW_IDX_W-1:0] ROW_FIRST  = 2'd0;
  localparam logic [ROW_IDX_W-1:0] ROW_SECOND = 2'd1;
  localparam logic [ROW_IDX_W-1:0] ROW_THIRD  = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Saturating accumulate of one absolute byte difference
  function automatic sum_t sat_add(input sum_t acc, input byte_t d);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W + 1 - BYTE_W){1'b0}}, d};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  function automatic byte_t abs_diff(input byte_t a, input byte_t b);
    return (a > b) ? byte_t'(a - b) : byte_t'(b - a);
  endfunction

endpackage

[hw/rtl/row_sad_interlace_detect.sv]
// Top level: row SAD interlace detector over two line-store memories.
// Throughput: one byte per cycle; the input stalls while a result waits in the accumulate
//   stage behind a full output register, for as long as the receiver holds off.
// Result: row 2's last byte is registered into stage 1, whose sums then load the output register.
// Each byte reads both line stores at its column (registered read), then the sums update.
// Reset: counters and sums clear, the block waits for a frame start; line stores are not cleared.
module row_sad_interlace_detect #(
  parameter int unsigned MAX_ROW_BYTES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: row_bytes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rsid_pkg::ROW_BYTES_W-1:0]    cfg_data_i,
  // Byte stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rsid_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] pixel_byte
  input  logic                                s_axis_tuser,  // [0] frame_start
  // Result out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [17:0] sad_first_second, [35:18] sad_first_third, [53:36] sad_second_third,
  // [54] looks_interlaced, [55] zero
  output logic [rsid_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import rsid_pkg::*;

  localparam int unsigned AW    = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_ROW_BYTES + 1);

  // Configuration register
  logic [ROW_BYTES_W-1:0] row_bytes_q;
  logic [LEN_W-1:0]       eff_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RST;
    end else if (cfg_valid_i) begin
      row_bytes_q <= cfg_data_i;
    end
  end

  // Clamp the row length to 1..MAX_ROW_BYTES
  always_comb begin
    if (row_bytes_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(row_bytes_q) > MAX_ROW_BYTES) begin
      eff_len = LEN_W'(MAX_ROW_BYTES);
    end else begin
      eff_len = LEN_W'(row_bytes_q);
    end
  end

  // Stage 0: position tracking, store writes, store reads
  logic [ROW_IDX_W-1:0] row_q, row_d, row_cur;
  logic [AW-1:0]        col_q, col_d, col_cur;
  logic                 done_q, done_d;
  logic                 s_fire, active, row_last, emit0, stall;

  logic                 s1_valid_q, s1_start_q, s1_emit_q;
  logic [ROW_IDX_W-1:0] s1_row_q;
  byte_t                s1_byte_q;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign row_cur = s_axis_tuser ? ROW_FIRST : row_q;
  assign col_cur = s_axis_tuser ? '0 : col_q;
  assign active  = s_axis_tuser || !done_q;
  assign row_last = (LEN_W'(col_cur) + LEN_W'(1)) >= eff_len;
  assign emit0   = active && row_last && (row_cur == ROW_THIRD);

  // Hold the input while a result waits behind a full output register
  assign stall         = s1_valid_q && s1_emit_q && m_axis_tvalid;
  assign s_axis_tready = !stall;

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    done_d = done_q;
    if (s_fire && active) begin
      done_d = 1'b0;
      if (row_last) begin
        col_d = '0;
        row_d = row_cur + ROW_IDX_W'(1);
        if (row_cur == ROW_THIRD) begin
          done_d = 1'b1;
        end
      end else begin
        col_d = col_cur + AW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= ROW_FIRST;
      col_q  <= '0;
      done_q <= 1'b1;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      done_q <= done_d;
    end
  end

  // Line stores; a row is always written before it is read
  byte_t first_mem  [MAX_ROW_BYTES];
  byte_t second_mem [MAX_ROW_BYTES];
  byte_t first_rd_q, second_rd_q;
  logic  mem_en;

  assign mem_en = s_fire && active;

  always_ff @(posedge clk_i) begin
    if (mem_en && (row_cur == ROW_FIRST)) begin
      first_mem[col_cur] <= s_axis_tdata;
    end
    if (mem_en && (row_cur == ROW_SECOND)) begin
      second_mem[col_cur] <= s_axis_tdata;
    end
    if (mem_en) begin
      first_rd_q  <= first_mem[col_cur];
      second_rd_q <= second_mem[col_cur];
    end
  end

  // Stage 1 control and payload
  logic s1_fire;
  assign s1_fire = s1_valid_q && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!stall) begin
      s1_valid_q <= mem_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      s1_start_q <= s_axis_tuser;
      s1_emit_q  <= emit0;
      s1_row_q   <= row_cur;
      s1_byte_q  <= s_axis_tdata;
    end
  end

  // Stage 1: absolute differences and saturating sums
  sum_t acc01_q, acc02_q, acc12_q;
  sum_t acc01_d, acc02_d, acc12_d;
  sum_t base01, base02, base12;

  always_comb begin
    base01  = s1_start_q ? '0 : acc01_q;
    base02  = s1_start_q ? '0 : acc02_q;
    base12  = s1_start_q ? '0 : acc12_q;
    acc01_d = base01;
    acc02_d = base02;
    acc12_d = base12;
    priority if (s1_row_q == ROW_SECOND) begin
      acc01_d = sat_add(base01, abs_diff(first_rd_q, s1_byte_q));
    end else if (s1_row_q == ROW_THIRD) begin
      acc02_d = sat_add(base02, abs_diff(first_rd_q, s1_byte_q));
      acc12_d = sat_add(base12, abs_diff(second_rd_q, s1_byte_q));
    end else begin
      acc01_d = base01;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc01_q <= '0;
      acc02_q <= '0;
      acc12_q <= '0;
    end else if (s1_fire) begin
      acc01_q <= acc01_d;
      acc02_q <= acc02_d;
      acc12_q <= acc12_d;
    end
  end

  // Output register: load on the last byte of row 2, drop on transfer
  logic out_valid_q;
  sum_t out01_q, out02_q, out12_q;
  logic interlaced;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_emit_q) begin
      out01_q <= acc01_d;
      out02_q <= acc02_d;
      out12_q <= acc12_d;
    end
  end

  assign interlaced    = {out02_q, 1'b0} < {1'b0, out01_q};
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, interlaced, out12_q, out02_q, out01_q};

  // A result never lands on a full output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_emit_q |-> !out_valid_q)
    else $error("result loaded over a pending result");

  // Input is held back only for a waiting result in stage 1
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && s1_emit_q)
    else $error("input stalled without a waiting result");

  // Analysis stops after the last byte of row 2
  a_done_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && emit0 |=> done_q && s1_valid_q && s1_emit_q)
    else $error("analysis not closed after result");

  // A frame start always enters stage 1 as row 0
  a_start_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_start_q |-> s1_row_q == ROW_FIRST)
    else $error("frame start not on row 0");

  // Row counter never passes the third row while analysis runs
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_q |-> row_q != 2'd3)
    else $error("row index out of range");

endmodule
